// ===== hdl/swsi_pkg.sv =====
`default_nettype none

package swsi_pkg;

    // store geometry
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // beat field widths
    localparam int REQ_W     = 2;
    localparam int POS_W     = 5;
    localparam int LIM_W     = 6;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_READ   = 2'd2,
        REQ_RESIZE = 2'd3
    } req_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic do_append;
        logic do_resize;
        logic do_read;
        logic do_ovf;
        logic ins_start;
        logic ins_step;
        logic ins_shift;
        logic ins_place;
        logic use_carry;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic greater;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_store_sorted_insert_top.sv =====
// bounded sample window with sorted insert
//
// input beat (s_ group): s_tuser carries the request kind (append, sorted
// insert, indexed read, resize), s_tdata carries sample, position and new limit.
// every accepted beat yields exactly one result beat on the m_ group with the
// read value, hit and overflow flags and the entry count after the request.
//
// sequencing: one request is handled at a time, and the next beat is only
// accepted once the result of the last has gone to the output register.
// append, read, resize, a dropped insert and an insert into an empty window
// go through execute and done only. a sorted insert into n entries scans all
// n from the oldest, one per cycle, moving every entry past the insert point
// up one slot on the way, with a separate place step when entries move,
// through the single read and single write port of the entry ram.
//
// reset: aresetn low empties the window and sets the limit to the full depth;
// ram contents are not cleared, only entries below the count are ever read.
// stall: the result sits in an output register; a new beat is accepted while
// it waits, and the next result holds in the datapath until m_tready frees it.
`default_nettype none

module sliding_window_store_sorted_insert_top import swsi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input beat
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // sample[31:0], position[36:32], new_limit[42:37], zero pad
    input  wire logic [REQ_W-1:0]      s_tuser,   // req_type[1:0]
    // result beat
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // read_data[31:0], hit[32], overflow[33], fill[39:34]
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: accept, execute, insert scan, shift and place, emit
    swsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry ram as a ring, count, limit and output register
    swsi_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/swsi_ctrl.sv =====
`default_nettype none

module swsi_ctrl import swsi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_PLACE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (sts.req)
                    REQ_APPEND: cmd.do_append = 1'b1;
                    REQ_READ:   cmd.do_read   = 1'b1;
                    REQ_RESIZE: cmd.do_resize = 1'b1;
                    REQ_INSERT: begin
                        if (sts.full) begin
                            cmd.do_ovf = 1'b1;
                        end else if (sts.empty) begin
                            cmd.ins_place = 1'b1;
                        end else begin
                            cmd.ins_start = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    default: cmd.do_resize = 1'b1;
                endcase
            end
            ST_SCAN: begin
                // one entry compared per cycle, walking from the oldest
                if (sts.greater) begin
                    cmd.ins_shift = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ST_PLACE;
                    end else begin
                        cmd.ins_step = 1'b1;
                        state_next   = ST_SHIFT;
                    end
                end else if (sts.idx_last) begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.ins_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                // every later entry moves up one slot, carried through a register
                cmd.ins_shift = 1'b1;
                cmd.use_carry = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.ins_step = 1'b1;
                end
            end
            ST_PLACE: begin
                cmd.ins_place = 1'b1;
                cmd.use_carry = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/swsi_dp.sv =====
`default_nettype none

module swsi_dp import swsi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [REQ_W-1:0]      s_tuser,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    // latched request
    req_t                     req_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [LIM_W-1:0]         nl_reg;

    // window state, entries live in a ring starting at head
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              hit_reg, ovf_reg;
    logic [DATA_W-1:0] carry_reg;

    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_valid_reg, m_valid_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic [CNT_W-1:0]  nl_clamp;
    logic [CNT_W-1:0]  excess;
    logic              read_in_range;
    logic [ADDR_W-1:0] idx_up;
    logic [DATA_W-1:0] ins_data;

    assign nl_clamp = (nl_reg == '0) ? CNT_W'(1) :
                      ((CNT_W'(nl_reg) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(nl_reg));
    assign excess        = count_reg - nl_clamp;
    assign read_in_range = (CNT_W'(pos_reg) < count_reg);
    assign idx_up        = idx_reg + ADDR_W'(1);
    assign ins_data      = cmd.use_carry ? carry_reg : sample_reg;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        if (cmd.do_append) begin
            if (count_reg >= limit_reg) begin
                head_next = head_reg + ADDR_W'(1);
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.do_resize) begin
            limit_next = nl_clamp;
            if (count_reg > nl_clamp) begin
                head_next  = head_reg + excess[ADDR_W-1:0];
                count_next = nl_clamp;
            end
        end
        if (cmd.ins_place) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        idx_next = idx_reg;
        rd_en    = 1'b0;
        rd_addr  = head_reg + pos_reg;
        if (cmd.do_read) begin
            rd_en = read_in_range;
        end
        if (cmd.ins_start) begin
            idx_next = '0;
            rd_en    = 1'b1;
            rd_addr  = head_reg;
        end
        if (cmd.ins_step) begin
            idx_next = idx_up;
            rd_en    = 1'b1;
            rd_addr  = head_reg + idx_up;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg + count_reg[ADDR_W-1:0];
        wr_data = sample_reg;
        if (cmd.do_append) begin
            wr_en = 1'b1;
        end
        if (cmd.ins_shift) begin
            wr_en   = 1'b1;
            wr_addr = head_reg + idx_reg;
            wr_data = ins_data;
        end
        if (cmd.ins_place) begin
            wr_en   = 1'b1;
            wr_addr = head_reg + count_reg[ADDR_W-1:0];
            wr_data = ins_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= req_t'(s_tuser);
            sample_reg <= s_tdata[DATA_W-1:0];
            pos_reg    <= s_tdata[DATA_W +: POS_W];
            nl_reg     <= s_tdata[DATA_W+POS_W +: LIM_W];
            hit_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            if (cmd.do_read) begin
                hit_reg <= read_in_range;
            end
            if (cmd.do_ovf) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.ins_shift) begin
            carry_reg <= rd_data_reg;
        end
        idx_reg <= idx_next;
        if (cmd.emit) begin
            m_data_reg <= {count_reg, ovf_reg, hit_reg,
                           (hit_reg ? rd_data_reg : {DATA_W{1'b0}})};
        end
    end

    assign m_valid_next = cmd.emit | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            limit_reg   <= DEPTH_CNT;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign sts.req      = req_reg;
    assign sts.full     = (count_reg >= DEPTH_CNT);
    assign sts.empty    = (count_reg == '0);
    assign sts.greater  = ($signed(rd_data_reg) > sample_reg);
    assign sts.idx_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign sts.out_free = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    a_limit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (limit_reg != '0) && (limit_reg <= DEPTH_CNT))
        else $error("limit out of range");

    a_walk_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_start |-> ((count_reg != '0) && (count_reg < DEPTH_CNT)))
        else $error("insert walk started on empty or full store");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("result emitted over an untaken beat");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_place |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("sorted insert did not grow the store");

endmodule

`default_nettype wire
